// ----- rtl/fbm_pkg.sv -----
// ============================================================================
// fbm_pkg : shared constants and helpers for the fractal value noise block
// Hash constants, register indexes, field widths and the 32-bit mixer steps.
// ============================================================================
package fbm_pkg;

    localparam int POS_W      = 32;
    localparam int OUT_W      = 17;
    localparam int INV_W      = 26;
    localparam int AMT_W      = 17;
    localparam int SEED_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LAT_BITS   = 20;
    localparam int NOISE_LAT  = 7;

    localparam logic [31:0] MIX_C1        = 32'h7feb352d;
    localparam logic [31:0] MIX_C2        = 32'h846ca68b;
    localparam logic [31:0] OCT_SEED_STEP = 32'h9e3779b9;

    // per-axis offsets added to the wrapped lattice index before mixing
    localparam logic [2:0][31:0] AXIS_OFS = {32'h85ebca6b, 32'h9e3779b9, 32'h0};
    // seed offsets of the three warp lookups, x in the lowest slot
    localparam logic [2:0][31:0] WARP_SEED_OFS = {32'd307, 32'd211, 32'd101};

    // x / 10 as (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 2^22
    localparam logic [19:0] DIV10_MUL   = 20'd838861;
    localparam int          DIV10_SHIFT = 23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_SIZE = 3'd0,
        CFG_WARP     = 3'd1,
        CFG_DETAIL   = 3'd2,
        CFG_CONTRAST = 3'd3,
        CFG_SEED     = 3'd4
    } t_cfg_idx;

    function automatic logic [31:0] mix_pre(input logic [31:0] h);
        logic [31:0] x;
        x = h ^ (h >> 16);
        return 32'(x * MIX_C1);
    endfunction

    function automatic logic [31:0] mix_mid(input logic [31:0] m);
        logic [31:0] x;
        x = m ^ (m >> 15);
        return 32'(x * MIX_C2);
    endfunction

    function automatic logic [31:0] mix_post(input logic [31:0] m);
        return m ^ (m >> 16);
    endfunction

endpackage

// ----- rtl/fbm_point_if.sv -----
// ============================================================================
// fbm_point_if : input channel carrying one surface point per item
// Valid/ready handshake with the three signed Q16.16 coordinates.
// ============================================================================
interface fbm_point_if;
    logic                              valid;
    logic                              ready;
    logic signed [fbm_pkg::POS_W-1:0]  pos_x;
    logic signed [fbm_pkg::POS_W-1:0]  pos_y;
    logic signed [fbm_pkg::POS_W-1:0]  pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ----- rtl/fbm_noise_if.sv -----
// ============================================================================
// fbm_noise_if : output channel carrying one noise value per item
// Valid/ready handshake with the unsigned Q1.16 result.
// ============================================================================
interface fbm_noise_if;
    logic                        valid;
    logic                        ready;
    logic [fbm_pkg::OUT_W-1:0]   noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// ----- rtl/fbm_noise.sv -----
// ============================================================================
// fbm_noise : pipelined hashed-lattice value noise lookup
// Seven stages: axis hashes, corner hashes, quintic fade, trilinear blend.
// A side word travels alongside with the same latency.
// ============================================================================
module fbm_noise #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                                               i_clk,
    input  logic                                               i_en,
    input  logic [2:0][FRAC_BITS+fbm_pkg::LAT_BITS-1:0]        i_pt,
    input  logic [31:0]                                        i_seed,
    input  logic [SIDE_W-1:0]                                  i_side,
    output logic [FRAC_BITS-1:0]                               o_noise,
    output logic [SIDE_W-1:0]                                  o_side
);
    import fbm_pkg::*;

    localparam int F = FRAC_BITS;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    function automatic logic [F-1:0] fmul(input logic [F-1:0] a, input logic [F-1:0] b);
        logic [2*F-1:0] p;
        p = a * b;
        return p[2*F-1:F];
    endfunction

    function automatic logic [F:0] fade(input logic [F-1:0] t3, input logic [F-1:0] t4,
                                        input logic [F-1:0] t5);
        logic signed [F+5:0] f;
        f = $signed({6'b0, t5}) * 6 - $signed({6'b0, t4}) * 15 + $signed({6'b0, t3}) * 10;
        if (f < 0) begin
            return '0;
        end else if (f > $signed({5'b0, ONE})) begin
            return ONE;
        end
        return f[F:0];
    endfunction

    // a + floor((b - a) * t / 2^F), same as the two-term blend
    function automatic logic [F-1:0] lerp(input logic [F-1:0] a, input logic [F-1:0] b,
                                          input logic [F:0] t);
        logic signed [F:0]     dd;
        logic signed [F+1:0]   ts;
        logic signed [2*F+1:0] pr;
        logic signed [2*F+1:0] s;
        dd = $signed({1'b0, b}) - $signed({1'b0, a});
        ts = $signed({1'b0, t});
        pr = dd * ts;
        s  = $signed({{(F+2){1'b0}}, a}) + (pr >>> F);
        return s[F-1:0];
    endfunction

    logic [2:0][1:0][31:0] s1_ax;
    logic [7:0][31:0]      s3_x;
    logic [7:0][F-1:0]     s5_cv;

    logic [2:0][1:0][31:0] r_m1, r_m2;
    logic [7:0][31:0]      r_c3, r_c4;
    logic [31:0]           r_seed1, r_seed2;
    logic [2:0][F-1:0]     r_t1, r_t2sq, r_t2, r_t3cu, r_t3, r_t3p3, r_t3p4;
    logic [2:0][F:0]       r_fade4;
    logic [F:0]            r_fy5, r_fz5, r_fz6;
    logic [3:0][F-1:0]     r_e5;
    logic [1:0][F-1:0]     r_f6;
    logic [F-1:0]          r_n7;
    logic [NOISE_LAT-1:0][SIDE_W-1:0] r_side;

    always_comb begin
        logic [LAT_BITS-1:0] lat;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 2; j++) begin
                lat = i_pt[k][F+LAT_BITS-1:F] + LAT_BITS'(j);
                s1_ax[k][j] = mix_pre(32'(lat) + AXIS_OFS[k]);
            end
        end
    end

    always_comb begin
        logic [2:0] ci;
        for (int i = 0; i < 8; i++) begin
            ci = 3'(i);
            s3_x[i] = r_seed2 ^ mix_post(r_m2[0][ci[0]]) ^ mix_post(r_m2[1][ci[1]])
                      ^ mix_post(r_m2[2][ci[2]]);
        end
    end

    always_comb begin
        logic [31:0] hv;
        for (int i = 0; i < 8; i++) begin
            hv = mix_post(r_c4[i]);
            s5_cv[i] = hv[31 -: F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1    <= s1_ax;
            r_seed1 <= i_seed;
            r_seed2 <= r_seed1;
            for (int k = 0; k < 3; k++) begin
                r_t1[k]   <= i_pt[k][F-1:0];
                r_t2sq[k] <= fmul(i_pt[k][F-1:0], i_pt[k][F-1:0]);
                for (int j = 0; j < 2; j++) begin
                    r_m2[k][j] <= mix_mid(r_m1[k][j]);
                end
                r_t2[k]    <= r_t1[k];
                r_t3cu[k]  <= fmul(r_t2sq[k], r_t1[k]);
                r_t3[k]    <= r_t2[k];
                r_t3p3[k]  <= r_t3cu[k];
                r_t3p4[k]  <= fmul(r_t3cu[k], r_t2[k]);
                r_fade4[k] <= fade(r_t3p3[k], r_t3p4[k], fmul(r_t3p4[k], r_t3[k]));
            end
            for (int i = 0; i < 8; i++) begin
                r_c3[i] <= mix_pre(s3_x[i]);
                r_c4[i] <= mix_mid(r_c3[i]);
            end
            for (int e = 0; e < 4; e++) begin
                r_e5[e] <= lerp(s5_cv[2*e], s5_cv[2*e+1], r_fade4[0]);
            end
            r_fy5   <= r_fade4[1];
            r_fz5   <= r_fade4[2];
            r_f6[0] <= lerp(r_e5[0], r_e5[1], r_fy5);
            r_f6[1] <= lerp(r_e5[2], r_e5[3], r_fy5);
            r_fz6   <= r_fz5;
            r_n7    <= lerp(r_f6[0], r_f6[1], r_fz6);
            r_side[0] <= i_side;
            for (int s = 1; s < NOISE_LAT; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_noise = r_n7;
    assign o_side  = r_side[NOISE_LAT-1];

endmodule

// ----- rtl/fbm_octave.sv -----
// ============================================================================
// fbm_octave : one octave cell of the fractal sum
// Looks up noise at the point, adds the weighted value, scales the weight
// and doubles the point for the next cell.
// ============================================================================
module fbm_octave #(
    parameter int FRAC_BITS = 16,
    parameter int OCT_IDX   = 0,
    parameter int WW        = 21,
    parameter int TW        = 25,
    parameter int AW        = 41
) (
    input  logic                                         i_clk,
    input  logic                                         i_en,
    input  logic [2:0][FRAC_BITS+fbm_pkg::LAT_BITS-1:0]  i_pt,
    input  logic [AW-1:0]                                i_acc,
    input  logic [TW-1:0]                                i_total,
    input  logic [WW-1:0]                                i_weight,
    input  logic [31:0]                                  i_seed,
    input  logic [16:0]                                  i_persist,
    output logic [2:0][FRAC_BITS+fbm_pkg::LAT_BITS-1:0]  o_pt,
    output logic [AW-1:0]                                o_acc,
    output logic [TW-1:0]                                o_total,
    output logic [WW-1:0]                                o_weight
);
    import fbm_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int NW = F + LAT_BITS;
    localparam int SW = 3*NW + AW + TW + WW;
    localparam logic [31:0] SEED_ADD = 32'(32'(OCT_IDX) * OCT_SEED_STEP);

    logic [F-1:0]           noise;
    logic [SW-1:0]          side;
    logic [2:0][NW-1:0]     d_pt;
    logic [AW-1:0]          d_acc;
    logic [TW-1:0]          d_total;
    logic [WW-1:0]          d_weight;
    logic [WW+F-1:0]        wn;
    logic [WW+16:0]         wg;

    logic [2:0][NW-1:0]     r_pt;
    logic [AW-1:0]          r_acc;
    logic [TW-1:0]          r_total;
    logic [WW-1:0]          r_weight;

    fbm_noise #(.FRAC_BITS(F), .SIDE_W(SW)) u_noise (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_pt    (i_pt),
        .i_seed  (i_seed + SEED_ADD),
        .i_side  ({i_pt, i_acc, i_total, i_weight}),
        .o_noise (noise),
        .o_side  (side)
    );

    assign {d_pt, d_acc, d_total, d_weight} = side;
    assign wn = d_weight * noise;
    assign wg = d_weight * i_persist;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pt[k] <= d_pt[k] << 1;
            end
            r_acc    <= d_acc + AW'(wn);
            r_total  <= d_total + TW'(d_weight);
            r_weight <= wg[WW+15:16];
        end
    end

    assign o_pt     = r_pt;
    assign o_acc    = r_acc;
    assign o_total  = r_total;
    assign o_weight = r_weight;

endmodule

// ----- rtl/fbm_div_step.sv -----
// ============================================================================
// fbm_div_step : one restoring-division cell
// Resolves one quotient bit of the weighted mean and hands the partial
// remainder to the next cell.
// ============================================================================
module fbm_div_step #(
    parameter int FRAC_BITS = 16,
    parameter int AW        = 41,
    parameter int TW        = 25,
    parameter int BIT       = 0
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [AW-1:0]         i_rem,
    input  logic [TW-1:0]         i_total,
    input  logic [FRAC_BITS-1:0]  i_quot,
    output logic [AW-1:0]         o_rem,
    output logic [TW-1:0]         o_total,
    output logic [FRAC_BITS-1:0]  o_quot
);
    logic [AW:0]            trial;
    logic [AW-1:0]          r_rem;
    logic [TW-1:0]          r_total;
    logic [FRAC_BITS-1:0]   r_quot;

    assign trial = (AW+1)'(i_total) << BIT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_total <= i_total;
            if ({1'b0, i_rem} >= trial) begin
                r_rem  <= AW'({1'b0, i_rem} - trial);
                r_quot <= i_quot | (FRAC_BITS'(1) << BIT);
            end else begin
                r_rem  <= i_rem;
                r_quot <= i_quot;
            end
        end
    end

    assign o_rem   = r_rem;
    assign o_total = r_total;
    assign o_quot  = r_quot;

endmodule

// ----- rtl/fbm_value_noise_3d.sv -----
// Throughput: one item per cycle; every stage is a register cell in one chain.
// Chain: scale, warp lookup, one cell per octave, one divider cell per quotient bit, output register.
// A result not taken holds the whole chain until the sink is ready.
// Reset clears all valid bits and loads the register reset values; payload is not reset.
// ============================================================================
// fbm_value_noise_3d : fractal 3D value noise with domain warp
// Scales the point, warps it, sums the octaves, normalizes, applies contrast.
// ============================================================================
module fbm_value_noise_3d #(
    parameter int OCTAVE_COUNT  = 4,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    fbm_point_if.sink                           i_point,
    fbm_noise_if.source                         o_noise,
    input  logic                                i_cfg_we,
    input  logic [fbm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fbm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import fbm_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int NW  = F + LAT_BITS;
    localparam int PW  = NW + 1;
    localparam int WW  = 17 + OCTAVE_COUNT;
    localparam int TW  = WW + 4;
    localparam int AW  = TW + F;
    localparam int LAT = 10 + (NOISE_LAT + 1) * OCTAVE_COUNT + F;
    localparam int SH_R = (F >= 16) ? F - 16 : 0;
    localparam int SH_L = (F < 16) ? 16 - F : 0;
    localparam logic [F-1:0] HALF = F'(1) << (F - 1);
    localparam logic [F:0]   ONE  = (F+1)'(1) << F;

    // configuration
    logic [INV_W-1:0]  r_inv_size;
    logic [AMT_W-1:0]  r_warp, r_detail, r_contrast;
    logic [SEED_W-1:0] r_seed;
    logic [16:0]       r_persist;
    logic [22:0]       r_gain;
    logic [19:0]       detail7;
    logic [39:0]       persist_full;
    logic [33:0]       csq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_size <= INV_W'(65536);
            r_warp     <= '0;
            r_detail   <= AMT_W'(32768);
            r_contrast <= '0;
            r_seed     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INV_SIZE: r_inv_size <= i_cfg_data[INV_W-1:0];
                CFG_WARP:     r_warp     <= i_cfg_data[AMT_W-1:0];
                CFG_DETAIL:   r_detail   <= i_cfg_data[AMT_W-1:0];
                CFG_CONTRAST: r_contrast <= i_cfg_data[AMT_W-1:0];
                CFG_SEED:     r_seed     <= i_cfg_data[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    assign detail7      = {3'b0, r_detail} * 20'd7;
    assign persist_full = {20'b0, detail7} * {20'b0, DIV10_MUL};
    assign csq          = {17'b0, r_contrast} * {17'b0, r_contrast};

    // derived factors, refreshed every cycle from the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persist <= 17'd22937;
            r_gain    <= 23'd65536;
        end else begin
            r_persist <= persist_full[DIV10_SHIFT+16:DIV10_SHIFT];
            r_gain    <= 23'd65536 + 23'(csq[33:16]) * 23'd15;
        end
    end

    // flow control
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en            = !r_vld[LAT-1] || o_noise.ready;
    assign i_point.ready = en;
    assign o_noise.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_point.valid};
        end
    end

    // scale
    logic signed [2:0][POS_W-1:0]         pos;
    logic signed [POS_W+INV_W:0]          sprod [3];
    logic [2:0][PW-1:0]                   r_p0;

    assign pos = {i_point.pos_z, i_point.pos_y, i_point.pos_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sprod[k] = $signed(pos[k]) * $signed({1'b0, r_inv_size});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_p0[k] <= sprod[k][32-F+PW-1 -: PW];
            end
        end
    end

    // warp: three lookups at half scale, one per axis
    logic [2:0][NW-1:0]  q;
    logic [2:0][F-1:0]   wn;
    logic [2:0][NW-1:0]  wp;
    logic [2:0][NW-1:0]  r_pw;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q[k] = r_p0[k][PW-1:1];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_warp
        logic signed [F+1:0]  d;
        logic signed [NW-1:0] dw;

        fbm_noise #(.FRAC_BITS(F), .SIDE_W(NW)) u_noise (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_pt    (q),
            .i_seed  (r_seed + WARP_SEED_OFS[k]),
            .i_side  (r_p0[k][NW-1:0]),
            .o_noise (wn[k]),
            .o_side  (wp[k])
        );

        assign d  = $signed({1'b0, wn[k], 1'b0}) - $signed({1'b0, ONE});
        assign dw = (d * $signed({1'b0, r_warp})) >>> 16;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pw[k] <= wp[k] + dw;
            end
        end
    end

    // octave chain
    logic [OCTAVE_COUNT:0][2:0][NW-1:0] c_pt;
    logic [OCTAVE_COUNT:0][AW-1:0]      c_acc;
    logic [OCTAVE_COUNT:0][TW-1:0]      c_total;
    logic [OCTAVE_COUNT:0][WW-1:0]      c_weight;

    assign c_pt[0]     = r_pw;
    assign c_acc[0]    = '0;
    assign c_total[0]  = '0;
    assign c_weight[0] = WW'(65536);

    for (genvar o = 0; o < OCTAVE_COUNT; o++) begin : g_oct
        fbm_octave #(.FRAC_BITS(F), .OCT_IDX(o), .WW(WW), .TW(TW), .AW(AW)) u_oct (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_pt      (c_pt[o]),
            .i_acc     (c_acc[o]),
            .i_total   (c_total[o]),
            .i_weight  (c_weight[o]),
            .i_seed    (r_seed),
            .i_persist (r_persist),
            .o_pt      (c_pt[o+1]),
            .o_acc     (c_acc[o+1]),
            .o_total   (c_total[o+1]),
            .o_weight  (c_weight[o+1])
        );
    end

    // mean = acc / total, one quotient bit per cell, most significant first
    logic [F:0][AW-1:0] d_rem;
    logic [F:0][TW-1:0] d_tot;
    logic [F:0][F-1:0]  d_quot;

    assign d_rem[0]  = c_acc[OCTAVE_COUNT];
    assign d_tot[0]  = c_total[OCTAVE_COUNT];
    assign d_quot[0] = '0;

    for (genvar j = 0; j < F; j++) begin : g_div
        fbm_div_step #(.FRAC_BITS(F), .AW(AW), .TW(TW), .BIT(F-1-j)) u_div (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_rem   (d_rem[j]),
            .i_total (d_tot[j]),
            .i_quot  (d_quot[j]),
            .o_rem   (d_rem[j+1]),
            .o_total (d_tot[j+1]),
            .o_quot  (d_quot[j+1])
        );
    end

    // contrast about one half, clamp, rescale
    logic signed [F:0]    cdiff;
    logic signed [F+24:0] cprod;
    logic signed [F+24:0] cres;
    logic [F:0]           clamped;
    logic [F+17:0]        cwide;
    logic [OUT_W-1:0]     n_noise_value;
    logic [OUT_W-1:0]     r_noise_value;

    always_comb begin
        cdiff = $signed({1'b0, d_quot[F]}) - $signed({1'b0, HALF});
        cprod = cdiff * $signed({1'b0, r_gain});
        cres  = (cprod >>> 16) + $signed({{25{1'b0}}, HALF});
        if (cres < 0) begin
            clamped = '0;
        end else if (cres > $signed({{24{1'b0}}, ONE})) begin
            clamped = ONE;
        end else begin
            clamped = cres[F:0];
        end
        cwide         = (F+18)'(clamped);
        n_noise_value = OUT_W'((cwide >> SH_R) << SH_L);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_noise_value <= n_noise_value;
        end
    end

    assign o_noise.noise_value = r_noise_value;

    // checks
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_noise.valid |-> i_point.ready)
        else $error("input stalled with no result pending");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_noise.valid)
        else $error("result valid right after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_noise.valid |-> o_noise.noise_value <= OUT_W'(65536))
        else $error("noise value above one");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_noise.valid && !o_noise.ready |=> o_noise.valid && $stable(r_vld))
        else $error("pipeline moved while output stalled");

endmodule

// ----- tb/sv/tb_fbm_value_noise_3d.sv -----
// ============================================================================
// tb_fbm_value_noise_3d : self-checking bench for the fractal value noise block
// Streams surface points through the block under several register settings
// and compares every noise value with a bit-accurate predictor.
// ============================================================================
module tb_fbm_value_noise_3d;
    timeunit 1ns;
    timeprecision 1ps;
    import fbm_pkg::*;

    localparam int OCT      = 4;
    localparam int FB       = 16;
    localparam int LATENCY  = 10 + 8 * OCT + FB;
    localparam int N_RANDOM = 1150;
    localparam longint ONE  = 64'sd65536;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    fbm_point_if point_ch ();
    fbm_noise_if noise_ch ();

    fbm_value_noise_3d #(.OCTAVE_COUNT(OCT), .FRACTION_BITS(FB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_point(point_ch.sink), .o_noise(noise_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [25:0] inv_size_q;
    logic [16:0] warp_q, detail_q, contrast_q;
    logic [31:0] seed_q;

    logic [16:0] noise_expected[$];
    int mismatches = 0;
    longint cycle_count = 0;
    bit calm_phase = 1'b0;

    function automatic longint shr_fl(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] hash32(logic [31:0] h);
        h = h ^ (h >> 16);
        h = h * 32'h7feb352d;
        h = h ^ (h >> 15);
        h = h * 32'h846ca68b;
        return h ^ (h >> 16);
    endfunction

    function automatic longint lattice_val(logic [31:0] sd, logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c);
        logic [31:0] h;
        h = hash32(sd ^ hash32(a & 32'hfffff) ^ hash32((b & 32'hfffff) + 32'h9e3779b9)
                   ^ hash32((c & 32'hfffff) + 32'h85ebca6b));
        return longint'(h >> 16);
    endfunction

    function automatic longint quintic(longint t);
        longint t2, t3, t4, t5, f;
        t2 = (t * t) >> FB;
        t3 = (t2 * t) >> FB;
        t4 = (t3 * t) >> FB;
        t5 = (t4 * t) >> FB;
        f = 6 * t5 - 15 * t4 + 10 * t3;
        if (f < 0) f = 0;
        if (f > ONE) f = ONE;
        return f;
    endfunction

    function automatic longint mix_lin(longint a, longint b, longint t);
        return (a * (ONE - t) + b * t) >> FB;
    endfunction

    function automatic longint lattice_noise(longint px, longint py, longint pz,
                                             logic [31:0] sd);
        logic [31:0] ix, iy, iz;
        longint tx, ty, tz, e0, e1, e2, e3;
        longint cv[8];
        ix = 32'(px >>> FB) & 32'hfffff;
        iy = 32'(py >>> FB) & 32'hfffff;
        iz = 32'(pz >>> FB) & 32'hfffff;
        tx = quintic(px & (ONE - 1));
        ty = quintic(py & (ONE - 1));
        tz = quintic(pz & (ONE - 1));
        for (int i = 0; i < 8; i++)
            cv[i] = lattice_val(sd, ix + i[0], iy + i[1], iz + i[2]);
        e0 = mix_lin(cv[0], cv[1], tx);
        e1 = mix_lin(cv[2], cv[3], tx);
        e2 = mix_lin(cv[4], cv[5], tx);
        e3 = mix_lin(cv[6], cv[7], tx);
        return mix_lin(mix_lin(e0, e1, ty), mix_lin(e2, e3, ty), tz);
    endfunction

    function automatic logic [16:0] predict_noise(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z);
        longint p[3], q[3], d[3];
        longint wt, total, acc, g, mean, c2, gain, r;
        logic [31:0] raw[3];
        logic [31:0] wofs[3];
        raw[0] = x; raw[1] = y; raw[2] = z;
        wofs[0] = 32'd101; wofs[1] = 32'd211; wofs[2] = 32'd307;
        for (int i = 0; i < 3; i++)
            p[i] = shr_fl(longint'($signed(raw[i])) * longint'(inv_size_q), 32 - FB);
        if (warp_q != 0) begin
            for (int i = 0; i < 3; i++) q[i] = shr_fl(p[i], 1);
            for (int i = 0; i < 3; i++)
                d[i] = 2 * lattice_noise(q[0], q[1], q[2], seed_q + wofs[i]) - ONE;
            for (int i = 0; i < 3; i++) p[i] += shr_fl(d[i] * longint'(warp_q), 16);
        end
        wt = 65536; total = 0; acc = 0;
        g = (longint'(detail_q) * 7) / 10;
        for (int o = 0; o < OCT; o++) begin
            acc += wt * lattice_noise(p[0], p[1], p[2], seed_q + 32'(o) * 32'h9e3779b9);
            total += wt;
            wt = (wt * g) >> 16;
            for (int i = 0; i < 3; i++) p[i] *= 2;
        end
        mean = acc / total;
        c2 = (longint'(contrast_q) * longint'(contrast_q)) >> 16;
        gain = 65536 + 15 * c2;
        r = shr_fl((mean - ONE / 2) * gain, 16) + ONE / 2;
        if (r < 0) r = 0;
        if (r > ONE) r = ONE;
        return 17'(r);
    endfunction

    function automatic bit idle_now();
        return !calm_phase && ($urandom_range(99) < 11);
    endfunction

    // result checker and sink stall
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && noise_ch.valid && noise_ch.ready) begin
            if (noise_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected noise value %0d", noise_ch.noise_value);
            end else begin
                logic [16:0] want;
                want = noise_expected.pop_front();
                if (noise_ch.noise_value !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %0d, got %0d", want,
                                 noise_ch.noise_value);
                end
            end
        end
    end

    always @(negedge i_clk) noise_ch.ready <= i_rst_n && !idle_now();

    always @(posedge i_clk) begin
        if (cycle_count > 400000) begin
            $display("FAIL fbm_value_noise_3d");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_INV_SIZE: inv_size_q = val[25:0];
            CFG_WARP:     warp_q = val[16:0];
            CFG_DETAIL:   detail_q = val[16:0];
            CFG_CONTRAST: contrast_q = val[16:0];
            CFG_SEED:     seed_q = val;
            default: ;
        endcase
    endtask

    // drive one point; caller is at a falling edge, valid stays up for the next item
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              bit known, logic [16:0] known_val);
        while (idle_now()) begin
            point_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.pos_x <= x;
        point_ch.pos_y <= y;
        point_ch.pos_z <= z;
        noise_expected = {noise_expected, known ? known_val : predict_noise(x, y, z)};
        do @(posedge i_clk); while (!point_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        point_ch.valid <= 1'b0;
        while (noise_expected.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(40 << 16))) - 32'(20 << 16);
            2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return $urandom_range(1) ? 32'h80000000 + $urandom_range(3)
                                              : 32'h7fffffff - $urandom_range(3);
        endcase
    endfunction

    typedef struct {
        logic [31:0] x, y, z;
        bit known;
        logic [16:0] val;
    } t_point_row;

    // origin, extremes, lattice points and fractions
    t_point_row directed[9] = '{
        '{32'h0, 32'h0, 32'h0, 0, 0},
        '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0},
        '{32'h80000000, 32'h80000000, 32'h80000000, 0, 0},
        '{32'h80000000, 32'h7fffffff, 32'h0, 0, 0},
        '{32'hffffffff, 32'h00000001, 32'hffff0000, 0, 0},
        '{32'h00010000, 32'h00020000, 32'h00030000, 0, 0},
        '{32'h00008000, 32'h00008000, 32'h00008000, 0, 0},
        '{32'h0000ffff, 32'hffff0001, 32'h12345678, 0, 0},
        '{32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 0, 0}
    };

    initial begin
        point_ch.valid = 1'b0;
        point_ch.pos_x = '0;
        point_ch.pos_y = '0;
        point_ch.pos_z = '0;
        noise_ch.ready = 1'b0;
        inv_size_q = 26'd65536; warp_q = '0; detail_q = 17'd32768;
        contrast_q = '0; seed_q = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_point(directed[i].x, directed[i].y, directed[i].z,
                       directed[i].known, directed[i].val);
        drain();

        // full contrast, full warp, full detail, high seed, large scale
        write_reg(CFG_INV_SIZE, 32'd65536000);
        write_reg(CFG_WARP, 32'd65536);
        write_reg(CFG_DETAIL, 32'd65536);
        write_reg(CFG_CONTRAST, 32'd65536);
        write_reg(CFG_SEED, 32'hffffffff);
        foreach (directed[i])
            send_point(directed[i].x, directed[i].y, directed[i].z, 0, 0);
        drain();
        // smallest scale and zero detail: any fractional origin is fixed
        write_reg(CFG_INV_SIZE, 32'd66);
        write_reg(CFG_DETAIL, 32'd0);
        write_reg(CFG_WARP, 32'd1);
        foreach (directed[i])
            send_point(directed[i].x, directed[i].y, directed[i].z, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            calm_phase = (ph == 3);
            write_reg(CFG_INV_SIZE, (ph == 7) ? 32'd0 : $urandom_range(65536000, 66));
            write_reg(CFG_WARP, (ph % 3 == 0) ? 32'd0 : $urandom_range(65536));
            write_reg(CFG_DETAIL, (ph == 5) ? 32'h1ffff : $urandom_range(65536));
            write_reg(CFG_CONTRAST, (ph == 6) ? 32'h1ffff : $urandom_range(65536));
            write_reg(CFG_SEED, $urandom());
            // out-of-range index is ignored by the block
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'd7;
            i_cfg_data <= $urandom();
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            for (int n = 0; n < N_RANDOM / 8; n++)
                send_point(rand_coord(), rand_coord(), rand_coord(), 0, 0);
            drain();
        end
        calm_phase = 1'b0;

        if (mismatches == 0 && noise_expected.size() == 0) begin
            $display("PASS fbm_value_noise_3d");
        end else begin
            $display("FAIL fbm_value_noise_3d");
        end
        $finish;
    end
endmodule
